### sv/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg
// Token codes, precedence and classification helpers for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package ifp_pkg;

  // Input token code, four bits wide.
  typedef logic [3:0] kind_t;

  localparam kind_t KIND_NUM   = 4'd0;
  localparam kind_t KIND_ADD   = 4'd1;
  localparam kind_t KIND_SUB   = 4'd2;
  localparam kind_t KIND_MUL   = 4'd3;
  localparam kind_t KIND_DIV   = 4'd4;
  localparam kind_t KIND_POW   = 4'd5;
  localparam kind_t KIND_SIN   = 4'd6;
  localparam kind_t KIND_COS   = 4'd7;
  localparam kind_t KIND_OPEN  = 4'd8;
  localparam kind_t KIND_CLOSE = 4'd9;
  localparam kind_t KIND_END   = 4'd10;

  // Operator precedence: power binds tightest, then multiply and divide.
  localparam logic [2:0] PREC_POW  = 3'd4;
  localparam logic [2:0] PREC_MUL  = 3'd3;
  localparam logic [2:0] PREC_ADD  = 3'd2;
  localparam logic [2:0] PREC_NONE = 3'd0;

  function automatic logic [2:0] prec(input kind_t k);
    logic [2:0] p;
    case (k)
      KIND_POW:           p = PREC_POW;
      KIND_MUL, KIND_DIV: p = PREC_MUL;
      KIND_ADD, KIND_SUB: p = PREC_ADD;
      default:            p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_op(input kind_t k);
    return (k >= KIND_ADD) && (k <= KIND_POW);
  endfunction

  function automatic logic is_fn(input kind_t k);
    return (k == KIND_SIN) || (k == KIND_COS);
  endfunction

endpackage

### sv/ifp_ram.sv
// ----------------------------------------------------------------------------
// ifp_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ifp_ram #(
  parameter int Width = 4,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: takes one coded infix token per request and emits
// postfix tokens, keeping the operator stack in a RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ----------------------------------
//  in        in_valid_i / in_ready_o      token_kind_i, number_value_i
//  out       out_valid_o / out_ready_i    out_kind_o, out_value_o,
//                                         last_of_run_o, expression_done_o,
//                                         overflow_o
//
//  A request is accepted in the idle state and pops one stack entry per cycle
//  while the output is free, reading the next top through the registered
//  read port of the stack RAM; all but a push end with a release state.
//  Reset clears the stack count and overflow flag but not the RAM, and a
//  full output register with out_ready_i low stalls the pop sequence.
module infix_to_postfix_converter
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3:0]             token_kind_i,
  input  logic [VALUE_WIDTH-1:0] number_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             out_kind_o,
  output logic [VALUE_WIDTH-1:0] out_value_o,
  output logic                   last_of_run_o,
  output logic                   expression_done_o,
  output logic                   overflow_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CntOne  = CW'(1);
  localparam logic [CW-1:0] CntTwo  = CW'(2);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPPOP = 3'd1;
  localparam logic [2:0] S_CLPOP = 3'd2;
  localparam logic [2:0] S_CLFN  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  kind_t                  top_q, top_d;
  logic                   fresh_q, fresh_d;
  kind_t                  kind_q, kind_d;
  logic                   overflow_q, overflow_d;
  logic                   pend_vld_q, pend_vld_d;
  kind_t                  pend_kind_q, pend_kind_d;
  logic [VALUE_WIDTH-1:0] pend_val_q, pend_val_d;

  logic                   ovld_q;
  logic [2:0]             okind_q;
  logic [VALUE_WIDTH-1:0] oval_q;
  logic                   olast_q, odone_q, oovf_q;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  kind_t                  ram_wdata, ram_rdata;
  kind_t                  top_w;
  logic                   out_free, go;
  logic                   emit_en, finish_en, out_load;
  kind_t                  emit_kind;
  logic [VALUE_WIDTH-1:0] emit_val;
  logic [CW-1:0]          cnt_m2;

  // Operator stack storage.
  ifp_ram #(
    .Width ($bits(kind_t)),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The top of stack comes straight from the RAM in the cycle after a pop.
  assign top_w     = fresh_q ? ram_rdata : top_q;
  assign out_free  = !ovld_q || out_ready_i;
  assign go        = out_free;
  assign cnt_m2    = cnt_q - CntTwo;
  assign ram_waddr = cnt_q[AW-1:0];
  assign ram_raddr = cnt_m2[AW-1:0];
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: push, pop one entry per cycle while the output is free, then release the held result.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    top_d       = top_w;
    fresh_d     = 1'b0;
    kind_d      = kind_q;
    overflow_d  = overflow_q;
    ram_we      = 1'b0;
    ram_wdata   = kind_q;
    ram_re      = 1'b0;
    emit_en     = 1'b0;
    emit_kind   = top_w;
    emit_val    = '0;
    finish_en   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = token_kind_i;
          if (token_kind_i == KIND_NUM) begin
            emit_en   = 1'b1;
            emit_kind = KIND_NUM;
            emit_val  = number_value_i;
            state_d   = S_DONE;
          end else if (is_op(token_kind_i)) begin
            state_d = S_OPPOP;
          end else if (is_fn(token_kind_i) || token_kind_i == KIND_OPEN) begin
            if (cnt_q == CntFull) begin
              overflow_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = token_kind_i;
              top_d     = token_kind_i;
              cnt_d     = cnt_q + CntOne;
            end
          end else if (token_kind_i == KIND_CLOSE) begin
            state_d = S_CLPOP;
          end else if (token_kind_i == KIND_END) begin
            state_d = S_END;
          end
        end
      end
      S_OPPOP: begin
        if (cnt_q != '0 && is_op(top_w) && prec(top_w) >= prec(kind_q)) begin
          if (go) begin
            emit_en = 1'b1;
            cnt_d   = cnt_q - CntOne;
            ram_re  = (cnt_q >= CntTwo);
            fresh_d = ram_re;
          end else begin
            fresh_d = 1'b0;
          end
        end else begin
          if (cnt_q == CntFull) begin
            overflow_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            top_d  = kind_q;
            cnt_d  = cnt_q + CntOne;
          end
          state_d = S_DONE;
        end
      end
      S_CLPOP: begin
        if (cnt_q != '0 && top_w != KIND_OPEN) begin
          if (go) begin
            emit_en = 1'b1;
            cnt_d   = cnt_q - CntOne;
            ram_re  = (cnt_q >= CntTwo);
            fresh_d = ram_re;
          end
        end else if (cnt_q != '0) begin
          // Drop the matching opening parenthesis.
          cnt_d   = cnt_q - CntOne;
          ram_re  = (cnt_q >= CntTwo);
          fresh_d = ram_re;
          state_d = S_CLFN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CLFN: begin
        if (cnt_q != '0 && is_fn(top_w)) begin
          if (go) begin
            emit_en = 1'b1;
            cnt_d   = cnt_q - CntOne;
            ram_re  = (cnt_q >= CntTwo);
            fresh_d = ram_re;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_END: begin
        if (cnt_q != '0) begin
          if (top_w == KIND_OPEN) begin
            cnt_d   = cnt_q - CntOne;
            ram_re  = (cnt_q >= CntTwo);
            fresh_d = ram_re;
          end else if (go) begin
            emit_en = 1'b1;
            cnt_d   = cnt_q - CntOne;
            ram_re  = (cnt_q >= CntTwo);
            fresh_d = ram_re;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          finish_en = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The newest result is held back until it is known whether it ends the run.
  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_kind_d = pend_kind_q;
    pend_val_d  = pend_val_q;
    if (emit_en) begin
      pend_vld_d  = 1'b1;
      pend_kind_d = emit_kind;
      pend_val_d  = emit_val;
    end else if (finish_en) begin
      pend_vld_d = 1'b0;
    end
  end

  assign out_load = (emit_en && pend_vld_q) || finish_en;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      fresh_q    <= 1'b0;
      overflow_q <= 1'b0;
      pend_vld_q <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fresh_q    <= fresh_d;
      overflow_q <= overflow_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (out_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    kind_q      <= kind_d;
    pend_kind_q <= pend_kind_d;
    pend_val_q  <= pend_val_d;
    if (out_load) begin
      okind_q <= pend_kind_q[2:0];
      oval_q  <= pend_val_q;
      olast_q <= finish_en;
      odone_q <= finish_en && (kind_q == KIND_END);
      oovf_q  <= overflow_q;
    end
  end

  assign out_valid_o       = ovld_q;
  assign out_kind_o        = okind_q;
  assign out_value_o       = oval_q;
  assign last_of_run_o     = olast_q;
  assign expression_done_o = odone_q;
  assign overflow_o        = oovf_q;

`ifndef SYNTHESIS
  // The stack count never passes the stack depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("stack count beyond depth");

  // No result is held back while waiting for a new request.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("held result left in idle");

  // The overflow flag is sticky.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |=> overflow_q)
    else $error("overflow flag cleared");

  // A fresh read only follows a pop that left at least one entry.
  a_fresh_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q |-> (cnt_q != '0))
    else $error("stack read with empty stack");

  // The expression end mark only appears on the last result of a run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && odone_q) |-> olast_q)
    else $error("done mark without last mark");
`endif

endmodule
